FILE: src/orse_pkg.sv
// Shared types and constants for the 1-Wire ROM search engine.
`timescale 1ns / 1ps

package orse_pkg;

  localparam int ROM_W           = 64;
  localparam int COUNT_W         = 7;
  localparam int POS_W           = 6;
  localparam int FAMILY_W        = 8;
  localparam int DEF_MAX_ENTRIES = 64;

  localparam logic [FAMILY_W-1:0] FAMILY_RESET = 8'h28;
  localparam logic [POS_W-1:0]    LAST_BIT     = 6'd63;

  // Input selector carried on in_tuser
  typedef enum logic [1:0] {
    FN_START  = 2'd0,
    FN_BIT    = 2'd1,
    FN_READ   = 2'd2,
    FN_UNUSED = 2'd3
  } func_t;

  // Result kind carried on out_tuser
  typedef enum logic [2:0] {
    ST_TAKEN    = 3'd0,
    ST_DONE     = 3'd1,
    ST_COMPLETE = 3'd2,
    ST_NORESP   = 3'd3,
    ST_IGNORED  = 3'd4,
    ST_READ     = 3'd5
  } status_t;

  // Tie mark: vld low means no tie recorded
  typedef struct packed {
    logic             vld;
    logic [POS_W-1:0] pos;
  } tie_t;

  // One result item as it moves through the output stages
  typedef struct packed {
    logic               write_bit;
    status_t            status;
    logic [ROM_W-1:0]   code;
    logic               stored;
    logic               full;
    logic [COUNT_W-1:0] count;
    logic               is_read;
    logic               entry_valid;
  } res_t;

endpackage

FILE: src/onewire_rom_search_engine.sv
// Top level of the 1-Wire ROM search engine: search state, step logic and output stages.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | tuser func, tdata bit pair and entry index
//  out_    | out | out_tvalid/out_tready| tuser status, tdata direction, code, flags
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_data family filter
//
// One item per cycle while in_tready is high; each item gives one result.
// The step logic updates the search registers in the accept cycle; a table read
// goes through the registered read port of the table memory into the result stage.
// rst_n is synchronous; the table content is not cleared, only the stored count.
// A stalled output holds one result in the output register and one in the result
// stage; in_tready drops only when both are full.
`timescale 1ns / 1ps

module onewire_rom_search_engine #(
  parameter int MAX_ENTRIES = orse_pkg::DEF_MAX_ENTRIES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input items
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [1:0]                      in_tuser,   // [1:0] func
  input  logic [7:0]                      in_tdata,   // [0] bit_value, [1] bit_complement,
                                                      // [7:2] entry_index
  // Result items
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [2:0]                      out_tuser,  // [2:0] status
  output logic [79:0]                     out_tdata,  // [0] write_bit, [64:1] rom_code,
                                                      // [65] rom_stored, [66] table_full,
                                                      // [73:67] found_count,
                                                      // [74] entry_valid, [79:75] zero
  // Family filter register
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [orse_pkg::FAMILY_W-1:0]   cfg_data
);
  import orse_pkg::*;

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_ENTRIES);

  // Search state
  logic [FAMILY_W-1:0] filter_r;
  logic [ROM_W-1:0]    rom_r, rom_nxt, rom_new;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  tie_t                lt_r, lt_nxt, lzt_r, lzt_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic                srch_r, srch_nxt;

  // Input fields
  func_t               func;
  logic                bv, bc;
  logic [POS_W-1:0]    idx;
  logic                in_acc;

  // Step outputs
  res_t                res;
  logic                dir;
  logic                tie;
  logic                we, re;

  // Output stages
  logic                p_vld_r, o_vld_r, p_adv;
  res_t                p_res_r, o_res_r, o_res_nxt;
  logic [ROM_W-1:0]    rd_data;

  assign func   = func_t'(in_tuser);
  assign bv     = in_tdata[0];
  assign bc     = in_tdata[1];
  assign idx    = in_tdata[7:2];
  assign in_acc = in_tvalid && in_tready;

  // Family filter register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_r <= FAMILY_RESET;
    end else if (cfg_valid) begin
      filter_r <= cfg_data;
    end
  end

  // Step logic: one item against the search state
  always_comb begin
    rom_nxt   = rom_r;
    rom_new   = rom_r;
    pos_nxt   = pos_r;
    lt_nxt    = lt_r;
    lzt_nxt   = lzt_r;
    count_nxt = count_r;
    srch_nxt  = srch_r;
    dir       = 1'b0;
    tie       = 1'b0;
    we        = 1'b0;
    re        = 1'b0;
    res       = '0;
    res.status = ST_IGNORED;
    if (in_acc) begin
      unique case (func)
        FN_START: begin
          count_nxt  = '0;
          lt_nxt     = '0;
          lzt_nxt    = '0;
          rom_nxt    = '0;
          pos_nxt    = '0;
          srch_nxt   = 1'b1;
          res.status = ST_TAKEN;
        end
        FN_READ: begin
          re              = 1'b1;
          res.status      = ST_READ;
          res.is_read     = 1'b1;
          res.entry_valid = ({1'b0, idx} < count_r) && ({1'b0, idx} < MAX_CNT);
        end
        FN_BIT: begin
          if (srch_r) begin
            if (bv && bc) begin
              srch_nxt   = 1'b0;
              res.status = ST_NORESP;
            end else begin
              tie = (bv == bc);
              // Pick the direction: forced bit, or the tie rule
              if (!tie) begin
                dir = bv;
              end else if (lt_r.vld && pos_r == lt_r.pos) begin
                dir = 1'b1;
              end else if (!lt_r.vld || pos_r > lt_r.pos) begin
                dir    = 1'b0;
                lt_nxt = '{vld: 1'b1, pos: pos_r};
              end else begin
                dir = rom_r[pos_r];
              end
              if (tie && !dir) begin
                lzt_nxt = '{vld: 1'b1, pos: pos_r};
              end
              rom_new[pos_r] = dir;
              rom_nxt        = rom_new;
              res.write_bit  = dir;
              res.status     = ST_TAKEN;
              // Finish the pass after the last bit
              if (pos_r == LAST_BIT) begin
                res.code = rom_new;
                if (rom_new[FAMILY_W-1:0] == filter_r) begin
                  if (count_r < MAX_CNT) begin
                    we         = 1'b1;
                    count_nxt  = count_r + 1'b1;
                    res.stored = 1'b1;
                  end else begin
                    res.full = 1'b1;
                  end
                end
                lt_nxt  = lzt_nxt;
                pos_nxt = '0;
                if (!lzt_nxt.vld) begin
                  srch_nxt   = 1'b0;
                  res.status = ST_COMPLETE;
                end else begin
                  res.status = ST_DONE;
                end
                lzt_nxt = '0;
              end else begin
                pos_nxt = pos_r + 1'b1;
              end
            end
          end
        end
        default: begin
          res.status = ST_IGNORED;
        end
      endcase
    end
    res.count = count_nxt;
  end

  // Search state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_r   <= '0;
      pos_r   <= '0;
      lt_r    <= '0;
      lzt_r   <= '0;
      count_r <= '0;
      srch_r  <= 1'b0;
    end else begin
      rom_r   <= rom_nxt;
      pos_r   <= pos_nxt;
      lt_r    <= lt_nxt;
      lzt_r   <= lzt_nxt;
      count_r <= count_nxt;
      srch_r  <= srch_nxt;
    end
  end

  // Table of found codes; a read never falls in the same cycle as a write
  orse_rom_table #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (we),
    .waddr (count_r[AW-1:0]),
    .wdata (rom_new),
    .re    (re),
    .rvld  (res.entry_valid),
    .raddr (idx[AW-1:0]),
    .rdata (rd_data)
  );

  // Advance the result stage into the output register when that is empty or being taken
  assign p_adv     = p_vld_r && (!o_vld_r || out_tready);
  assign in_tready = !p_vld_r || p_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      if (in_acc) begin
        p_vld_r <= 1'b1;
      end else if (p_adv) begin
        p_vld_r <= 1'b0;
      end
      if (p_adv) begin
        o_vld_r <= 1'b1;
      end else if (out_tready) begin
        o_vld_r <= 1'b0;
      end
    end
  end

  // Join table data to a read item on its way to the output register
  always_comb begin
    o_res_nxt = p_res_r;
    if (p_res_r.is_read) begin
      o_res_nxt.code = rd_data;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      p_res_r <= res;
    end
    if (p_adv) begin
      o_res_r <= o_res_nxt;
    end
  end

  assign out_tvalid = o_vld_r;
  assign out_tuser  = o_res_r.status;
  assign out_tdata  = {5'b0, o_res_r.entry_valid, o_res_r.count, o_res_r.full,
                       o_res_r.stored, o_res_r.code, o_res_r.write_bit};

  // The stored count never passes the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_CNT)
    else $error("stored count beyond table depth");

  // A start clears the count and arms the search
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && func == FN_START |=> srch_r && count_r == '0)
    else $error("start did not arm the search");

  // A stored code shows a non-zero count
  a_stored_count: assert property (@(posedge clk) disable iff (!rst_n)
    o_vld_r && o_res_r.stored |-> o_res_r.count != '0)
    else $error("stored code with zero count");

  // A blocked result stage keeps its item
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    p_vld_r && !p_adv |=> p_vld_r && $stable(p_res_r))
    else $error("result stage lost its item");

endmodule

FILE: src/orse_rom_table.sv
// Table of found ROM codes: one write port, one registered read port.
`timescale 1ns / 1ps

module orse_rom_table #(
  parameter int DEPTH = orse_pkg::DEF_MAX_ENTRIES,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [orse_pkg::ROM_W-1:0] wdata,
  input  logic                     re,
  input  logic                     rvld,
  input  logic [AW-1:0]            raddr,
  output logic [orse_pkg::ROM_W-1:0] rdata
);
  import orse_pkg::*;

  logic [ROM_W-1:0] mem [DEPTH];
  logic [ROM_W-1:0] q_r;
  logic             vld_r;

  // Write a newly stored code
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read on request, hold data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      q_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (re) begin
      vld_r <= rvld;
    end
  end

  // An index beyond the stored count reads as zero
  assign rdata = vld_r ? q_r : '0;

endmodule
